>>> src/uda_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic distance average package
// Shared constants, codes and payload types of the distance averaging block.
// ----------------------------------------------------------------------------
package uda_pkg;

  localparam int SENSORS_DEFAULT = 3;
  localparam int WINDOW_DEFAULT  = 5;

  localparam int PULSE_W = 24;
  localparam int DIST_W  = 16;
  localparam int SEL_IN_W = 2;

  // Distance in 1/128 cm is floor(pulse_width * 343 / 15625).
  localparam int DIST_PROD_W = 33;
  localparam int DIST_QUO_W  = 19;
  localparam logic [8:0]  DIST_MUL = 9'd343;
  localparam logic [13:0] DIST_DIV = 14'd15625;

  // Reciprocal estimate of the division, low by at most one.
  localparam int RECIP_SHIFT = 33;
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 20'd549755;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [15:0] MIN_DISTANCE_RST = 16'd256;
  localparam logic [15:0] MAX_DISTANCE_RST = 16'd51200;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic {
    CFG_MIN_DISTANCE = 1'b0,
    CFG_MAX_DISTANCE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [SEL_IN_W-1:0] sel;
    status_t             status;
    logic [DIST_W-1:0]   now;
  } front_item_t;

  typedef struct packed {
    status_t           status;
    logic [DIST_W-1:0] now;
    logic [DIST_W-1:0] avg;
  } result_t;

endpackage

>>> src/uda_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module uda_fifo import uda_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/uda_front.sv
// ----------------------------------------------------------------------------
// Distance front end
// Converts the pulse width to a distance and classifies the reading.
// ----------------------------------------------------------------------------
module uda_front import uda_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [SEL_IN_W-1:0] in_sel,
  input  logic                in_timed_out,
  input  logic [PULSE_W-1:0]  in_pulse,
  output logic                in_stall,
  input  logic [DIST_W-1:0]   min_distance,
  input  logic [DIST_W-1:0]   max_distance,
  output logic                item_push,
  output front_item_t         item,
  input  logic                item_full
);

  localparam int NSTG = 5;
  localparam int RPROD_W = DIST_PROD_W + RECIP_W;

  logic                   en;
  logic [NSTG-1:0]        vld_r;
  logic [SEL_IN_W-1:0]    sel_r [NSTG-1];
  logic                   tmo_r [NSTG-1];
  logic [DIST_PROD_W-1:0] prod1_r, prod2_r, prod3_r;
  logic [DIST_QUO_W-1:0]  qest2_r, qest3_r, quo4_r;
  logic [DIST_PROD_W-1:0] qmul3_r;
  logic [RPROD_W-1:0]     rprod;
  logic [DIST_PROD_W-1:0] rem4;
  front_item_t            item_r, item_nxt;

  assign en        = !(vld_r[NSTG-1] && item_full);
  assign in_stall  = !en;
  assign item_push = vld_r[NSTG-1] && !item_full;
  assign item      = item_r;

  assign rprod = RPROD_W'(prod1_r) * RPROD_W'(RECIP_MUL);
  assign rem4  = prod3_r - qmul3_r;

  always_comb begin
    item_nxt.sel = sel_r[NSTG-2];
    item_nxt.now = '0;
    if (tmo_r[NSTG-2]) begin
      item_nxt.status = ST_TIMEOUT;
    end else if (quo4_r < DIST_QUO_W'(min_distance) ||
                 quo4_r > DIST_QUO_W'(max_distance)) begin
      item_nxt.status = ST_RANGE;
    end else begin
      item_nxt.status = ST_VALID;
      item_nxt.now    = quo4_r[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r[0] <= in_sel;
      tmo_r[0] <= in_timed_out;
      for (int i = 1; i < NSTG - 1; i++) begin
        sel_r[i] <= sel_r[i-1];
        tmo_r[i] <= tmo_r[i-1];
      end
      prod1_r <= DIST_PROD_W'(in_pulse) * DIST_PROD_W'(DIST_MUL);
      prod2_r <= prod1_r;
      qest2_r <= rprod[RECIP_SHIFT +: DIST_QUO_W];
      prod3_r <= prod2_r;
      qest3_r <= qest2_r;
      qmul3_r <= DIST_PROD_W'(qest2_r) * DIST_PROD_W'(DIST_DIV);
      quo4_r  <= qest3_r + DIST_QUO_W'(rem4 >= DIST_PROD_W'(DIST_DIV));
      item_r  <= item_nxt;
    end
  end

endmodule

>>> src/uda_back.sv
// ----------------------------------------------------------------------------
// Moving average back end
// Keeps one ring and running sum per sensor and averages the window.
// ----------------------------------------------------------------------------
module uda_back import uda_pkg::*; #(
  parameter int SENSORS = SENSORS_DEFAULT,
  parameter int WINDOW  = WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_empty,
  input  front_item_t item,
  output logic        item_pop,
  output logic        res_push,
  output result_t     res,
  input  logic        res_full
);

  localparam int SEL_W     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int WP_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = DIST_W + $clog2(WINDOW);
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int APROD_W   = SUM_W + AVG_SHIFT + 1;
  localparam logic [AVG_SHIFT:0] AVG_MUL =
    (AVG_SHIFT + 1)'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [DIST_W-1:0] ring_r [SENSORS][WINDOW];
  logic [WP_W-1:0]   wpos_r [SENSORS];
  logic [SUM_W-1:0]  sum_r  [SENSORS];
  logic [SENSORS-1:0] primed_r;

  logic              en, take, sel_ok, upd;
  logic [SEL_W-1:0]  idx;
  logic [DIST_W-1:0] old_entry;
  logic [SUM_W-1:0]  sum_nxt, sum_out;
  logic [WP_W-1:0]   wpos_nxt;
  logic              vb1_r, vb2_r;
  status_t           st1_r;
  logic [DIST_W-1:0] now1_r;
  logic [SUM_W-1:0]  sum1_r;
  logic [APROD_W-1:0] aprod;
  result_t           res_r;

  assign en       = !(vb2_r && res_full);
  assign take     = en && !item_empty;
  assign item_pop = take;
  assign res_push = vb2_r && !res_full;
  assign res      = res_r;

  assign idx       = SEL_W'(item.sel);
  assign sel_ok    = 32'(item.sel) < SENSORS;
  assign upd       = take && sel_ok && (item.status == ST_VALID);
  assign old_entry = ring_r[idx][wpos_r[idx]];
  assign wpos_nxt  = (wpos_r[idx] == WP_W'(WINDOW - 1)) ? '0 : wpos_r[idx] + 1'b1;
  assign aprod     = APROD_W'(sum1_r) * APROD_W'(AVG_MUL);

  always_comb begin
    if (primed_r[idx]) begin
      sum_nxt = sum_r[idx] - SUM_W'(old_entry) + SUM_W'(item.now);
    end else begin
      sum_nxt = SUM_W'(item.now) * SUM_W'(WINDOW);
    end
    if (!sel_ok) begin
      sum_out = '0;
    end else if (item.status == ST_VALID) begin
      sum_out = sum_nxt;
    end else begin
      sum_out = sum_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= '0;
      for (int s = 0; s < SENSORS; s++) begin
        wpos_r[s] <= '0;
        sum_r[s]  <= '0;
      end
    end else if (upd) begin
      primed_r[idx] <= 1'b1;
      wpos_r[idx]   <= wpos_nxt;
      sum_r[idx]    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SENSORS; s++) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (upd && idx == SEL_W'(s) &&
            (!primed_r[s] || wpos_r[s] == WP_W'(i))) begin
          ring_r[s][i] <= item.now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb1_r <= 1'b0;
      vb2_r <= 1'b0;
    end else if (en) begin
      vb1_r <= take;
      vb2_r <= vb1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r      <= item.status;
      now1_r     <= item.now;
      sum1_r     <= sum_out;
      res_r.status <= st1_r;
      res_r.now    <= now1_r;
      res_r.avg    <= aprod[AVG_SHIFT +: DIST_W];
    end
  end

endmodule

>>> src/ultrasonic_distance_average_unit.sv
// Throughput: one request per cycle when nothing stalls, set by the ring and running
// sum update per sensor in the back end, done as each request is taken.
// Reset: synchronous, active low; clears queues, pipeline valids, rings' sums,
// write positions and primed flags, and loads the distance limits.
// ----------------------------------------------------------------------------
// Ultrasonic distance average unit
// Echo width to distance conversion with a per-sensor moving average.
// ----------------------------------------------------------------------------
module ultrasonic_distance_average_unit import uda_pkg::*; #(
  parameter int SENSORS = SENSORS_DEFAULT,
  parameter int WINDOW  = WINDOW_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [SEL_IN_W-1:0] in_sensor_select,
  input  logic                in_timed_out,
  input  logic [PULSE_W-1:0]  in_pulse_width,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [1:0]          out_status,
  output logic [DIST_W-1:0]   out_distance_now,
  output logic [DIST_W-1:0]   out_distance_average,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  logic [DIST_W-1:0] min_distance_r, max_distance_r;
  logic              in_stall;
  logic              mid_push, mid_full, mid_pop, mid_empty;
  front_item_t       mid_in, mid_out;
  logic              res_push, res_full;
  result_t           res_in, res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_distance_r <= MIN_DISTANCE_RST;
      max_distance_r <= MAX_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIN_DISTANCE: min_distance_r <= cfg_wdata;
        CFG_MAX_DISTANCE: max_distance_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = in_stall;

  uda_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_push && !in_stall),
    .in_sel       (in_sensor_select),
    .in_timed_out (in_timed_out),
    .in_pulse     (in_pulse_width),
    .in_stall     (in_stall),
    .min_distance (min_distance_r),
    .max_distance (max_distance_r),
    .item_push    (mid_push),
    .item         (mid_in),
    .item_full    (mid_full)
  );

  uda_fifo #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_out),
    .empty     (mid_empty)
  );

  uda_back #(
    .SENSORS (SENSORS),
    .WINDOW  (WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_empty (mid_empty),
    .item       (mid_out),
    .item_pop   (mid_pop),
    .res_push   (res_push),
    .res        (res_in),
    .res_full   (res_full)
  );

  uda_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_out),
    .empty     (out_empty)
  );

  assign out_status           = res_out.status;
  assign out_distance_now     = res_out.now;
  assign out_distance_average = res_out.avg;

endmodule

>>> src/uda_checker.sv
// ----------------------------------------------------------------------------
// Distance average port checker
// Port-level properties of the distance averaging unit, bound to its top.
// ----------------------------------------------------------------------------
module uda_checker import uda_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [1:0]        out_status,
  input logic [DIST_W-1:0] out_distance_now,
  input logic [DIST_W-1:0] out_distance_average
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_VALID) |-> out_distance_now == '0)
    else $error("distance reported for a reading that is not valid");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status) &&
      $stable(out_distance_now) && $stable(out_distance_average)))
    else $error("waiting result changed before it was taken");

endmodule

bind ultrasonic_distance_average_unit uda_checker u_uda_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_full              (in_full),
  .out_empty            (out_empty),
  .out_pop              (out_pop),
  .out_status           (out_status),
  .out_distance_now     (out_distance_now),
  .out_distance_average (out_distance_average)
);
